// ----- design/awtm_pkg.sv -----
// Shared types, constants and codes for the analog window trimmed-mean block.
`timescale 1ns / 1ps
package awtm_pkg;

   localparam int CHANNELS   = 8;
   localparam int WINDOW_MAX = 32;
   localparam int CH_W       = 3;
   localparam int IDX_W      = 5;
   localparam int LEN_W      = 6;
   localparam int DATA_W     = 16;
   localparam int SUM_W      = 21;
   localparam int SPAN_W     = 4;
   localparam int RANK_W     = 5;
   localparam int ERR_W      = 6;
   localparam int ADDR_W     = CH_W + IDX_W;
   localparam int DEPTH      = CHANNELS * WINDOW_MAX;
   localparam int CSR_IDX_W  = 3;

   // error counter marks
   localparam logic [ERR_W-1:0] ERR_WRAP1 = 6'd20;
   localparam logic [ERR_W-1:0] ERR_WRAP2 = 6'd40;
   localparam logic [ERR_W-1:0] ERR_WRAP3 = 6'd60;
   localparam logic [ERR_W-1:0] ERR_MARK  = 6'd30;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_MAX = 3'd4;

   // register reset values
   localparam logic [LEN_W-1:0]  RST_WINDOW_LEN  = 6'd30;
   localparam logic [DATA_W-1:0] RST_CURRENT_MIN = 16'd1024;
   localparam logic [DATA_W-1:0] RST_CURRENT_MAX = 16'd8960;
   localparam logic [DATA_W-1:0] RST_VOLTAGE_MIN = 16'd0;
   localparam logic [DATA_W-1:0] RST_VOLTAGE_MAX = 16'd2560;

   // tag carried along with a window read
   localparam logic [1:0] RD_NONE  = 2'd0;
   localparam logic [1:0] RD_SHIFT = 2'd1;
   localparam logic [1:0] RD_VI    = 2'd2;
   localparam logic [1:0] RD_VJ    = 2'd3;

   typedef struct packed {
      logic                     req_type;
      logic [CH_W-1:0]          channel;
      logic signed [DATA_W-1:0] sample;
   } awtm_req_beat_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] filtered;
   } awtm_rsp_beat_type;

   typedef struct packed {
      logic             load_item;
      logic [1:0]       rd_kind;
      logic [IDX_W-1:0] rd_idx;
      logic             put_sample;
      logic             clear_err;
      logic             bump_err;
      logic             set_status;
      logic [1:0]       status_val;
      logic             rank_clear;
      logic             sum_clear;
      logic             acc_en;
      logic             div_start;
      logic             div_step;
      logic             div_finish;
      logic             rsp_load;
   } awtm_cmd_type;

   typedef struct packed {
      logic             is_query;
      logic             in_range;
      logic             ch_invalid;
      logic [LEN_W-1:0] len_eff;
      logic             out_free;
   } awtm_stat_type;

endpackage

// ----- design/analog_window_trimmed_mean.sv -----
// Top level of the eight-channel analog window trimmed-mean filter.
`timescale 1ns / 1ps
// One item is worked at a time; the next beat is taken once the result sits in
// the output register. For effective window length L (window_len, with zero
// read as 1 and values above 32 read as 32) a sample beat shifts the window
// one entry per cycle through the window memory (no shift when L is 1), then
// puts the new sample in; an out-of-range sample skips both. A query beat
// ranks every window entry against every other with a single comparator,
// then runs a bit-serial divide. A query on an invalid channel skips both.
// A stalled result holds the block for as long as the stall lasts. No clearing
// pass after reset: window entries read as zero until written.
module analog_window_trimmed_mean
   import awtm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  awtm_req_beat_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output awtm_rsp_beat_type    rsp_data
);

   awtm_cmd_type  cmd;
   awtm_stat_type stat;

   awtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   awtm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- design/awtm_dp.sv -----
// Datapath: config registers, window memory, rank counter, accumulator, divider.
`timescale 1ns / 1ps
module awtm_dp
   import awtm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata,
   input  awtm_req_beat_type     req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output awtm_rsp_beat_type     rsp_data,
   input  awtm_cmd_type          cmd,
   output awtm_stat_type         stat
);

   // config registers
   logic [LEN_W-1:0]         wl_ff;
   logic signed [DATA_W-1:0] cmin_ff, cmax_ff, vmin_ff, vmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= RST_WINDOW_LEN;
         cmin_ff <= RST_CURRENT_MIN;
         cmax_ff <= RST_CURRENT_MAX;
         vmin_ff <= RST_VOLTAGE_MIN;
         vmax_ff <= RST_VOLTAGE_MAX;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEN:  wl_ff   <= csr_wdata[LEN_W-1:0];
            CSR_CURRENT_MIN: cmin_ff <= csr_wdata;
            CSR_CURRENT_MAX: cmax_ff <= csr_wdata;
            CSR_VOLTAGE_MIN: vmin_ff <= csr_wdata;
            CSR_VOLTAGE_MAX: vmax_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective length, third and span
   logic [LEN_W-1:0]    len_eff;
   logic [13:0]         third_prod;
   logic [SPAN_W-1:0]   third;
   logic [LEN_W-1:0]    three_third;
   logic [SPAN_W-1:0]   span;

   always_comb begin
      if (wl_ff == '0)
         len_eff = LEN_W'(1);
      else if (wl_ff > LEN_W'(WINDOW_MAX))
         len_eff = LEN_W'(WINDOW_MAX);
      else
         len_eff = wl_ff;
      // divide by three through a reciprocal multiply, exact for len <= 32
      third_prod  = 14'(len_eff) * 14'd171;
      third       = third_prod[12:9];
      three_third = LEN_W'(third) + LEN_W'(third) + LEN_W'(third);
      span        = third + SPAN_W'(len_eff - three_third);
   end

   // current item
   awtm_req_beat_type item_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item)
         item_ff <= req_data;
   end

   // range check
   logic signed [DATA_W-1:0] lo, hi;
   logic                     cur_grp;
   assign cur_grp = (item_ff.channel < CH_W'(CHANNELS / 2));
   assign lo = cur_grp ? cmin_ff : vmin_ff;
   assign hi = cur_grp ? cmax_ff : vmax_ff;

   // error counters
   logic [ERR_W-1:0] err_ff [CHANNELS];
   logic [ERR_W-1:0] err_next;
   assign err_next = err_ff[item_ff.channel] + ERR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++)
            err_ff[c] <= '0;
      end else if (cmd.clear_err) begin
         err_ff[item_ff.channel] <= '0;
      end else if (cmd.bump_err) begin
         if (err_next == ERR_WRAP1 || err_next == ERR_WRAP2 || err_next == ERR_WRAP3)
            err_ff[item_ff.channel] <= ERR_MARK;
         else
            err_ff[item_ff.channel] <= err_next;
      end
   end

   // window memory with per-entry valid bits; invalid entries read as zero
   logic [DATA_W-1:0] win_mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [1:0]        rd_kind_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic signed [DATA_W-1:0] rd_val;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  last_idx;

   assign last_idx = IDX_W'(len_eff - LEN_W'(1));
   assign rd_addr  = {item_ff.channel, cmd.rd_idx};
   assign rd_val   = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {item_ff.channel, last_idx};
      wr_data = item_ff.sample;
      if (rd_kind_ff == RD_SHIFT) begin
         wr_en   = 1'b1;
         wr_addr = {item_ff.channel, IDX_W'(rd_idx_ff - IDX_W'(1))};
         wr_data = rd_val;
      end else if (cmd.put_sample) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         win_mem[wr_addr] <= wr_data;
      rd_data_ff <= win_mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
      rd_idx_ff  <= cmd.rd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_kind_ff <= RD_NONE;
      end else begin
         rd_kind_ff <= cmd.rd_kind;
         if (wr_en)
            vld_ff[wr_addr] <= 1'b1;
      end
   end

   // stable rank of the pivot entry
   logic signed [DATA_W-1:0] vi_ff;
   logic [IDX_W-1:0]         vi_idx_ff;
   logic [RANK_W-1:0]        rank_ff;

   always_ff @(posedge clock) begin
      if (rd_kind_ff == RD_VI) begin
         vi_ff     <= rd_val;
         vi_idx_ff <= rd_idx_ff;
      end
      if (cmd.rank_clear)
         rank_ff <= '0;
      else if (rd_kind_ff == RD_VJ &&
               (rd_val < vi_ff || (rd_val == vi_ff && rd_idx_ff < vi_idx_ff)))
         rank_ff <= rank_ff + RANK_W'(1);
   end

   // middle-part accumulator
   logic signed [SUM_W-1:0] sum_ff;
   logic [RANK_W-1:0]       hi_rank;
   assign hi_rank = RANK_W'(third) + RANK_W'(span);

   always_ff @(posedge clock) begin
      if (cmd.sum_clear)
         sum_ff <= '0;
      else if (cmd.acc_en && rank_ff >= RANK_W'(third) && rank_ff < hi_rank)
         sum_ff <= sum_ff + SUM_W'(vi_ff);
   end

   // restoring divider on the magnitude, one quotient bit a cycle
   logic [SUM_W-1:0]  dq_ff;
   logic [RANK_W-1:0] drem_ff;
   logic              neg_ff;
   logic [RANK_W:0]   dtrial;
   logic [RANK_W:0]   ddiff;
   assign dtrial = {drem_ff, dq_ff[SUM_W-1]};
   assign ddiff  = dtrial - (RANK_W + 1)'(span);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;
         drem_ff <= '0;
         neg_ff  <= sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         if (dtrial >= (RANK_W + 1)'(span)) begin
            drem_ff <= ddiff[RANK_W-1:0];
            dq_ff   <= {dq_ff[SUM_W-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial[RANK_W-1:0];
            dq_ff   <= {dq_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // result fields
   logic [1:0]               status_ff;
   logic signed [DATA_W-1:0] filt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         status_ff <= ST_OK;
         filt_ff   <= '0;
      end else begin
         if (cmd.set_status)
            status_ff <= cmd.status_val;
         if (cmd.div_finish)
            filt_ff <= neg_ff ? DATA_W'(-dq_ff[DATA_W-1:0]) : dq_ff[DATA_W-1:0];
      end
   end

   // output register
   logic              rsp_valid_ff;
   awtm_rsp_beat_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.status   <= status_ff;
         rsp_data_ff.filtered <= filt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to the controller
   assign stat.is_query   = (item_ff.req_type == REQ_QUERY);
   assign stat.in_range   = (item_ff.sample >= lo) && (item_ff.sample <= hi);
   assign stat.ch_invalid = (err_ff[item_ff.channel] >= ERR_MARK);
   assign stat.len_eff    = len_eff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- design/awtm_ctrl.sv -----
// Controller: sequences window shift, rank-select query and division.
`timescale 1ns / 1ps
module awtm_ctrl
   import awtm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  awtm_stat_type stat,
   output awtm_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_SHIFT = 4'd2;
   localparam logic [3:0] S_DRAIN = 4'd3;
   localparam logic [3:0] S_PUT   = 4'd4;
   localparam logic [3:0] S_QI    = 4'd5;
   localparam logic [3:0] S_QJ    = 4'd6;
   localparam logic [3:0] S_QEND  = 4'd7;
   localparam logic [3:0] S_QACC  = 4'd8;
   localparam logic [3:0] S_DIV0  = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [LEN_W-1:0] len_m1;

   assign len_m1    = stat.len_eff - LEN_W'(1);
   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd      = '0;
      cmd.rd_kind = RD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!stat.is_query) begin
               if (stat.in_range) begin
                  cmd.clear_err = 1'b1;
                  j_in          = LEN_W'(1);
                  state_in      = (len_m1 == '0) ? S_PUT : S_SHIFT;
               end else begin
                  cmd.bump_err   = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status_val = ST_RANGE;
                  state_in       = S_DONE;
               end
            end else if (stat.ch_invalid) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_INVALID;
               state_in       = S_DONE;
            end else begin
               cmd.sum_clear = 1'b1;
               i_in          = '0;
               state_in      = S_QI;
            end
         end
         S_SHIFT: begin
            cmd.rd_kind = RD_SHIFT;
            cmd.rd_idx  = j_ff[IDX_W-1:0];
            j_in        = j_ff + LEN_W'(1);
            if (j_ff == len_m1)
               state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_PUT;
         S_PUT: begin
            cmd.put_sample = 1'b1;
            state_in       = S_DONE;
         end
         S_QI: begin
            cmd.rd_kind    = RD_VI;
            cmd.rd_idx     = i_ff[IDX_W-1:0];
            cmd.rank_clear = 1'b1;
            j_in           = '0;
            state_in       = S_QJ;
         end
         S_QJ: begin
            cmd.rd_kind = RD_VJ;
            cmd.rd_idx  = j_ff[IDX_W-1:0];
            j_in        = j_ff + LEN_W'(1);
            if (j_ff == len_m1)
               state_in = S_QEND;
         end
         S_QEND: state_in = S_QACC;
         S_QACC: begin
            cmd.acc_en = 1'b1;
            i_in       = i_ff + LEN_W'(1);
            state_in   = (i_ff == len_m1) ? S_DIV0 : S_QI;
         end
         S_DIV0: begin
            cmd.div_start = 1'b1;
            j_in          = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            j_in         = j_ff + LEN_W'(1);
            if (j_ff == LEN_W'(SUM_W - 1))
               state_in = S_FIN;
         end
         S_FIN: begin
            cmd.div_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
